// ===== sv/kes_pkg.sv =====
// shared types, constants and helpers of the kronecker edge sampler
package kes_pkg;

  localparam int unsigned MAX_LOG_N_DEF = 48;
  localparam int unsigned WORD_W        = 31;
  localparam int unsigned S_TDATA_W     = 32;
  localparam int unsigned OUT_W         = 48;
  localparam int unsigned M_TDATA_W     = 2 * OUT_W;
  localparam int unsigned LOG_N_W       = 6;
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned HALF_W        = KEY_W / 2;
  localparam int unsigned CFG_ADDR_W    = 2;
  localparam int unsigned QUOT_W        = 20;

  localparam logic [LOG_N_W-1:0] LOG_N_RESET  = 6'd20;
  localparam logic [WORD_W-1:0]  REJECT_LIMIT = 31'd3647;
  localparam logic [HALF_W-1:0]  QUARTER      = 32'd2500;
  // floor(2^43 / 2500): quotient estimate is exact or one low for 31-bit words
  localparam logic [HALF_W-1:0]  RECIP        = 32'd3518437208;
  localparam int unsigned        RECIP_SHIFT  = 43;
  localparam logic [KEY_W-1:0]   MUL_KEY_A    = 64'h4519840211493211;
  localparam logic [KEY_W-1:0]   MUL_KEY_B    = 64'h3050852102C843A5;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LOG_N = 2'd0,
    CFG_KEY_A = 2'd1,
    CFG_KEY_B = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIV_MUL,
    DP_UPDATE,
    DP_ADD_A,
    DP_ADD_B,
    DP_MUL_LL,
    DP_MUL_HL,
    DP_MUL_LH,
    DP_REV,
    DP_SAVE_SRC,
    DP_EMIT
  } dp_op_e;

  typedef enum logic {
    KEY_SEL_A,
    KEY_SEL_B
  } key_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVMUL,
    S_UPDATE,
    S_ADD_A,
    S_ADD_B,
    S_MLL_A,
    S_MHL_A,
    S_MLH_A,
    S_REV_A,
    S_MLL_B,
    S_MHL_B,
    S_MLH_B,
    S_REV_B,
    S_SAVE,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e   op;
    key_sel_e key;
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [KEY_W-1:0] rev64(input logic [KEY_W-1:0] x);
    logic [KEY_W-1:0] r;
    for (int i = 0; i < KEY_W; i++) begin
      r[i] = x[KEY_W-1-i];
    end
    return r;
  endfunction

endpackage

// ===== sv/kes_ctrl.sv =====
// sequencer for word intake and the shared-multiplier vertex scrambling
module kes_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kes_pkg::dp_stat_t stat_i,
  output kes_pkg::dp_cmd_t  cmd_o
);
  import kes_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        tgt_pass_q, tgt_pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      tgt_pass_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      tgt_pass_q <= tgt_pass_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    tgt_pass_d = tgt_pass_q;
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NOP;
    cmd_o.key  = KEY_SEL_A;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_DIVMUL;
        end
      end
      S_DIVMUL: begin
        cmd_o.op = DP_DIV_MUL;
        state_d  = stat_i.reject ? S_IDLE : S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.op   = DP_UPDATE;
        tgt_pass_d = 1'b0;
        state_d    = stat_i.done ? S_ADD_A : S_IDLE;
      end
      S_ADD_A: begin
        cmd_o.op = DP_ADD_A;
        state_d  = S_ADD_B;
      end
      S_ADD_B: begin
        cmd_o.op = DP_ADD_B;
        state_d  = S_MLL_A;
      end
      S_MLL_A: begin
        cmd_o.op = DP_MUL_LL;
        state_d  = S_MHL_A;
      end
      S_MHL_A: begin
        cmd_o.op = DP_MUL_HL;
        state_d  = S_MLH_A;
      end
      S_MLH_A: begin
        cmd_o.op = DP_MUL_LH;
        state_d  = S_REV_A;
      end
      S_REV_A: begin
        cmd_o.op = DP_REV;
        state_d  = S_MLL_B;
      end
      S_MLL_B: begin
        cmd_o.op  = DP_MUL_LL;
        cmd_o.key = KEY_SEL_B;
        state_d   = S_MHL_B;
      end
      S_MHL_B: begin
        cmd_o.op  = DP_MUL_HL;
        cmd_o.key = KEY_SEL_B;
        state_d   = S_MLH_B;
      end
      S_MLH_B: begin
        cmd_o.op  = DP_MUL_LH;
        cmd_o.key = KEY_SEL_B;
        state_d   = S_REV_B;
      end
      S_REV_B: begin
        cmd_o.op = DP_REV;
        state_d  = tgt_pass_q ? S_EMIT : S_SAVE;
      end
      S_SAVE: begin
        // source done, run the same sequence on the target
        cmd_o.op   = DP_SAVE_SRC;
        tgt_pass_d = 1'b1;
        state_d    = S_ADD_A;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op   = DP_EMIT;
          tgt_pass_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/kes_dp.sv =====
// datapath: config registers, quadrant pick, bit gathering, scrambler, output word
module kes_dp #(
  parameter int unsigned MaxLogN = kes_pkg::MAX_LOG_N_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kes_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [kes_pkg::KEY_W-1:0]        cfg_data_i,
  input  logic [kes_pkg::WORD_W-1:0]       word_i,
  input  kes_pkg::dp_cmd_t                 cmd_i,
  output kes_pkg::dp_stat_t                stat_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [kes_pkg::OUT_W-1:0]        out_src_o,
  output logic [kes_pkg::OUT_W-1:0]        out_tgt_o
);
  import kes_pkg::*;

  logic [LOG_N_W-1:0] log_n_q;
  logic [KEY_W-1:0]   key_a_q, key_b_q;
  logic [LOG_N_W-1:0] level_q;
  logic [MaxLogN-1:0] src_q, tgt_q;
  logic [MaxLogN-1:0] tgt_hold_q;
  logic [WORD_W-1:0]  word_q;
  logic [KEY_W-1:0]   acc_q, x_q;
  logic [OUT_W-1:0]   src_res_q;
  logic               out_valid_q;
  logic [OUT_W-1:0]   out_src_q, out_tgt_q;

  // effective level count and reversal shift
  logic [LOG_N_W-1:0] lv;
  logic [LOG_N_W:0]   sh;
  logic [LOG_N_W-1:0] lvl_next;
  logic               done;

  always_comb begin
    if (log_n_q == '0) begin
      lv = LOG_N_W'(1);
    end else if (log_n_q > LOG_N_W'(MaxLogN)) begin
      lv = LOG_N_W'(MaxLogN);
    end else begin
      lv = log_n_q;
    end
  end

  assign sh       = (LOG_N_W + 1)'(KEY_W) - {1'b0, lv};
  assign lvl_next = level_q + LOG_N_W'(1);
  assign done     = (lvl_next >= lv);

  // quadrant = floor(word / 2500) mod 4, estimate corrected by one step
  logic [QUOT_W-1:0] q_est;
  logic [HALF_W-1:0] q_mul, q_rem;
  logic [1:0]        qsel;
  logic              s_raw, t_raw, flip, s_bit, t_bit;
  logic [MaxLogN-1:0] src_next, tgt_next;

  assign q_est = acc_q[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
  assign q_mul = HALF_W'(q_est) * QUARTER;
  assign q_rem = HALF_W'(word_q) - q_mul;
  assign qsel  = q_est[1:0] + 2'((q_rem >= QUARTER) ? 1 : 0);
  assign s_raw = qsel[0];
  assign t_raw = ~(qsel[1] ^ qsel[0]);
  // clip and flip while the prefixes still match
  assign flip  = (src_q == tgt_q) && s_raw && !t_raw;
  assign s_bit = flip ? 1'b0 : s_raw;
  assign t_bit = flip ? 1'b1 : t_raw;
  assign src_next = {src_q[MaxLogN-2:0], s_bit};
  assign tgt_next = {tgt_q[MaxLogN-2:0], t_bit};

  // shared 32x32 multiplier
  logic [KEY_W-1:0]  key_sel;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [KEY_W-1:0]  prod;

  assign key_sel = (cmd_i.key == KEY_SEL_A) ? (key_a_q | MUL_KEY_A) : (key_b_q | MUL_KEY_B);

  always_comb begin
    case (cmd_i.op)
      DP_DIV_MUL: begin
        mul_a = HALF_W'(word_q);
        mul_b = RECIP;
      end
      DP_MUL_HL: begin
        mul_a = x_q[KEY_W-1:HALF_W];
        mul_b = key_sel[HALF_W-1:0];
      end
      DP_MUL_LH: begin
        mul_a = x_q[HALF_W-1:0];
        mul_b = key_sel[KEY_W-1:HALF_W];
      end
      default: begin
        mul_a = x_q[HALF_W-1:0];
        mul_b = key_sel[HALF_W-1:0];
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // config, edge state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_n_q     <= LOG_N_RESET;
      key_a_q     <= '0;
      key_b_q     <= '0;
      level_q     <= '0;
      src_q       <= '0;
      tgt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_LOG_N: log_n_q <= cfg_data_i[LOG_N_W-1:0];
          CFG_KEY_A: key_a_q <= cfg_data_i;
          CFG_KEY_B: key_b_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == DP_UPDATE) begin
        if (done) begin
          level_q <= '0;
          src_q   <= '0;
          tgt_q   <= '0;
        end else begin
          level_q <= lvl_next;
          src_q   <= src_next;
          tgt_q   <= tgt_next;
        end
      end
      if (cmd_i.op == DP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD:    word_q <= word_i;
      DP_DIV_MUL: acc_q  <= prod;
      DP_UPDATE: begin
        x_q        <= KEY_W'(src_next);
        tgt_hold_q <= tgt_next;
      end
      DP_ADD_A:  x_q <= x_q + key_a_q;
      DP_ADD_B:  x_q <= x_q + key_b_q;
      DP_MUL_LL: acc_q <= prod;
      DP_MUL_HL, DP_MUL_LH: begin
        acc_q[KEY_W-1:HALF_W] <= acc_q[KEY_W-1:HALF_W] + prod[HALF_W-1:0];
      end
      DP_REV: x_q <= rev64(acc_q) >> sh;
      DP_SAVE_SRC: begin
        src_res_q <= x_q[OUT_W-1:0];
        x_q       <= KEY_W'(tgt_hold_q);
      end
      DP_EMIT: begin
        out_src_q <= src_res_q;
        out_tgt_q <= x_q[OUT_W-1:0];
      end
      default: ;
    endcase
  end

  assign stat_o.reject   = (word_q < REJECT_LIMIT);
  assign stat_o.done     = done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_src_o   = out_src_q;
  assign out_tgt_o   = out_tgt_q;

endmodule

// ===== sv/kronecker_edge_sampler.sv =====
// Kronecker edge sampler: one random word per level, scrambled edge out.
// Each word is taken, multiplied by the reciprocal, then used for the quadrant
// and bit update; a word below 3647 is dropped after the multiply. When log_n
// words have been used, both vertices are scrambled on one shared 32x32
// multiplier, which sets the edge tail: ten steps per vertex, one hand-over
// and one output load, which waits until the output register is free. The
// finished edge sits in an output register, and the next word is taken while
// it waits. log_n saturates to 1..MaxLogN.
module kronecker_edge_sampler #(
  parameter int unsigned MaxLogN = kes_pkg::MAX_LOG_N_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kes_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [kes_pkg::KEY_W-1:0]        cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [kes_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // random_word[30:0], pad
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [kes_pkg::M_TDATA_W-1:0]    m_axis_tdata   // source_vertex, target_vertex
);
  import kes_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [OUT_W-1:0] out_src, out_tgt;

  kes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kes_dp #(
    .MaxLogN (MaxLogN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .word_i      (s_axis_tdata[WORD_W-1:0]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_src_o   (out_src),
    .out_tgt_o   (out_tgt)
  );

  assign m_axis_tdata = {out_tgt, out_src};

endmodule

// ===== sv/kes_checker.sv =====
// port-level checks of the kronecker edge sampler, bound to the top level
module kes_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [kes_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // a taken word makes the block busy in the cycle after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a taken word");

  // a new edge is loaded only from the busy scramble tail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("edge appeared while input side was idle");

  // no edge during reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind kronecker_edge_sampler kes_checker u_kes_checker (.*);
